FILE: src/assert_macros.svh
// Assertion macros used by the cache bank RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DLRU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequence must hold in the cycle after its antecedent.
`define DLRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dlru_pkg.sv
package dlru_pkg;

    // Geometry of one cache.
    localparam int ENTRIES   = 16;
    localparam int KEY_BITS  = 31;
    localparam int DATA_BITS = 64;
    localparam int RANK_BITS = $clog2(ENTRIES);
    localparam int FILL_BITS = $clog2(ENTRIES + 1);
    localparam int CAP_BITS  = 5;
    localparam int CMP_BITS  = (FILL_BITS > CAP_BITS) ? FILL_BITS : CAP_BITS;

    // Field widths and stream packing.
    localparam int FUNC_BITS    = 2;
    localparam int STATUS_BITS  = 3;
    localparam int IN_BITS      = FUNC_BITS + KEY_BITS + DATA_BITS;
    localparam int IN_TDATA     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = STATUS_BITS + KEY_BITS + DATA_BITS;
    localparam int OUT_TDATA    = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Request kinds.
    localparam logic [FUNC_BITS-1:0] FUNC_GET = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_SET = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_POP = 2'd2;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_MISS     = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_HIT      = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_UPDATED  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_EVICTED  = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_POPPED   = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd6;

    // Capacity registers after reset.
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // One request as presented to a cache bank.
    typedef struct packed {
        logic                 valid;
        logic [FUNC_BITS-1:0] func;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] data;
    } dlru_req_t;

    // One result as produced by a cache bank.
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [KEY_BITS-1:0]    key;
        logic [DATA_BITS-1:0]   data;
    } dlru_res_t;

    // Capacity settings of both caches.
    typedef struct packed {
        logic [CAP_BITS-1:0] cap_first;
        logic [CAP_BITS-1:0] cap_second;
    } dlru_cfg_t;

endpackage

FILE: src/dual_lru_block_cache_core.sv
// Two independent fully associative LRU caches of 16 keyed 64-bit blocks each,
// selected per request by s_tuser. A get returns the payload on a hit, a set
// updates or inserts (evicting and reporting the least recent entry when the
// cache is at its configured capacity), and a pop removes and reports the least
// recent entry. One request is taken per cycle unless the result side stalls;
// each result passes through the input register and then the result register to
// the master side. The key match and rank update across the sixteen slots of the
// selected cache are combinational. Reset empties both caches at once, with no
// clearing pass, and sets both capacities to 16; capacities should be written
// only while no request is in flight.
module dual_lru_block_cache_core
    import dlru_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Request stream.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_TDATA-1:0]      s_tdata,   // func, lookup_key, write_data, zero pad
    input  logic                     s_tuser,   // which_cache
    // Result stream.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_TDATA-1:0]     m_tdata,   // status, out_key, out_data, zero pad
    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic                 in_valid_reg;
    logic [FUNC_BITS-1:0] in_func_reg;
    logic                 in_which_reg;
    logic [KEY_BITS-1:0]  in_key_reg;
    logic [DATA_BITS-1:0] in_data_reg;
    logic                 out_valid_reg;
    dlru_res_t            out_res_reg;
    logic                 fire;
    dlru_cfg_t            cfg;
    dlru_req_t            req_first;
    dlru_req_t            req_second;
    dlru_res_t            res_first;
    dlru_res_t            res_second;

    // The held request is processed once the result register can take it.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg  <= s_tdata[FUNC_BITS-1:0];
            in_key_reg   <= s_tdata[FUNC_BITS +: KEY_BITS];
            in_data_reg  <= s_tdata[FUNC_BITS + KEY_BITS +: DATA_BITS];
            in_which_reg <= s_tuser;
        end
    end

    // Capacity registers.
    dlru_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Route the request to the selected cache.
    always_comb
    begin
        req_first.valid  = fire && !in_which_reg;
        req_first.func   = in_func_reg;
        req_first.key    = in_key_reg;
        req_first.data   = in_data_reg;
        req_second       = req_first;
        req_second.valid = fire && in_which_reg;
    end

    dlru_bank u_bank_first (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_first),
        .capacity (cfg.cap_first),
        .res      (res_first)
    );

    dlru_bank u_bank_second (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_second),
        .capacity (cfg.cap_second),
        .res      (res_second)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= in_which_reg ? res_second : res_first;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA'({out_res_reg.data, out_res_reg.key, out_res_reg.status});

endmodule

FILE: src/dlru_cfg.sv
module dlru_cfg
    import dlru_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output dlru_cfg_t                cfg
);

    logic [CAP_BITS-1:0] cap_first_reg;
    logic [CAP_BITS-1:0] cap_second_reg;
    logic                wr_en;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Registers sit at byte addresses 0 and 4; bit 2 picks the register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_first_reg  <= CAP_RESET;
            cap_second_reg <= CAP_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2])
            begin
                cap_second_reg <= pwdata[CAP_BITS-1:0];
            end
            else
            begin
                cap_first_reg <= pwdata[CAP_BITS-1:0];
            end
        end
    end

    // Read back the addressed register.
    assign prdata = paddr[2] ? APB_DATA_BITS'(cap_second_reg) : APB_DATA_BITS'(cap_first_reg);

    assign cfg.cap_first  = cap_first_reg;
    assign cfg.cap_second = cap_second_reg;

endmodule

FILE: src/dlru_bank.sv
`include "assert_macros.svh"

module dlru_bank
    import dlru_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dlru_req_t           req,
    input  logic [CAP_BITS-1:0] capacity,
    output dlru_res_t           res
);

    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [RANK_BITS-1:0] rank_reg  [ENTRIES];
    logic [RANK_BITS-1:0] rank_next [ENTRIES];
    logic [KEY_BITS-1:0]  key_reg   [ENTRIES];
    logic [DATA_BITS-1:0] payload_reg [ENTRIES];
    logic [FILL_BITS-1:0] fill_reg;
    logic [FILL_BITS-1:0] fill_next;

    logic [ENTRIES-1:0]   hit_vec;
    logic [ENTRIES-1:0]   old_vec;
    logic [ENTRIES-1:0]   remove_vec;
    logic [ENTRIES-1:0]   kept_vec;
    logic [ENTRIES-1:0]   free_vec;
    logic [ENTRIES-1:0]   wr_vec;
    logic [FILL_BITS-1:0] fill_dec;
    logic [RANK_BITS-1:0] oldest_rank;
    logic [RANK_BITS-1:0] hit_rank;
    logic [DATA_BITS-1:0] hit_data;
    logic [KEY_BITS-1:0]  old_key;
    logic [DATA_BITS-1:0] old_data;
    logic                 hit_any;
    logic                 nonempty;
    logic                 full;
    logic                 do_touch;
    logic                 do_update;
    logic                 do_insert;
    logic                 do_evict;
    logic                 do_pop;

    // Ranks of valid slots are always 0 .. fill-1, so the oldest has rank fill-1.
    assign fill_dec    = fill_reg - FILL_BITS'(1);
    assign oldest_rank = fill_dec[RANK_BITS-1:0];
    assign nonempty    = (fill_reg != '0);

    // Associative match and oldest-entry select over all slots in parallel.
    always_comb
    begin
        hit_rank = '0;
        hit_data = '0;
        old_key  = '0;
        old_data = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == req.key);
            old_vec[i] = valid_reg[i] && (rank_reg[i] == oldest_rank);
            if (hit_vec[i])
            begin
                hit_rank = hit_rank | rank_reg[i];
                hit_data = hit_data | payload_reg[i];
            end
            if (old_vec[i])
            begin
                old_key  = old_key | key_reg[i];
                old_data = old_data | payload_reg[i];
            end
        end
    end

    assign hit_any = |hit_vec;

    // A capacity of zero acts as one; any capacity above the slot count acts as the slot count.
    assign full = nonempty && ((capacity == '0)
                               || (CMP_BITS'(fill_reg) >= CMP_BITS'(capacity))
                               || (fill_reg == FILL_BITS'(ENTRIES)));

    // Decode what this request does to the state.
    assign do_touch  = req.valid && hit_any && ((req.func == FUNC_GET) || (req.func == FUNC_SET));
    assign do_update = do_touch && (req.func == FUNC_SET);
    assign do_insert = req.valid && !hit_any && (req.func == FUNC_SET);
    assign do_evict  = do_insert && full;
    assign do_pop    = req.valid && nonempty && (req.func == FUNC_POP);

    // The first free slot is found after any eviction has taken place.
    assign remove_vec = (do_evict || do_pop) ? old_vec : '0;
    assign kept_vec   = valid_reg & ~remove_vec;
    assign free_vec   = ~kept_vec & (kept_vec + ENTRIES'(1));
    assign wr_vec     = do_insert ? free_vec : (do_update ? hit_vec : '0);

    // Next valid bits and recency ranks.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i] = kept_vec[i] || (do_insert && free_vec[i]);
            rank_next[i]  = rank_reg[i];
            if (do_touch)
            begin
                if (hit_vec[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + RANK_BITS'(1);
                end
            end
            else if (do_insert)
            begin
                if (free_vec[i])
                begin
                    rank_next[i] = '0;
                end
                else if (kept_vec[i])
                begin
                    rank_next[i] = rank_reg[i] + RANK_BITS'(1);
                end
            end
        end
    end

    // Fill count: an insert without eviction grows it, a pop shrinks it.
    always_comb
    begin
        fill_next = fill_reg;
        if (do_insert && !do_evict)
        begin
            fill_next = fill_reg + FILL_BITS'(1);
        end
        else if (do_pop)
        begin
            fill_next = fill_dec;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Key and payload storage, written on insert or update.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (wr_vec[i])
            begin
                key_reg[i]     <= req.key;
                payload_reg[i] <= req.data;
            end
        end
    end

    // Result of the request.
    always_comb
    begin
        res.status = ST_MISS;
        res.key    = '0;
        res.data   = '0;
        unique case (req.func)
            FUNC_GET:
            begin
                if (hit_any)
                begin
                    res.status = ST_HIT;
                    res.data   = hit_data;
                end
            end
            FUNC_SET:
            begin
                if (hit_any)
                begin
                    res.status = ST_UPDATED;
                end
                else if (full)
                begin
                    res.status = ST_EVICTED;
                    res.key    = old_key;
                    res.data   = old_data;
                end
                else
                begin
                    res.status = ST_INSERTED;
                end
            end
            FUNC_POP:
            begin
                if (nonempty)
                begin
                    res.status = ST_POPPED;
                    res.key    = old_key;
                    res.data   = old_data;
                end
                else
                begin
                    res.status = ST_EMPTY;
                end
            end
            default:
            begin
                res.status = ST_MISS;
            end
        endcase
    end

    // Keys held in a cache are unique, and a nonempty cache has exactly one oldest entry.
    `DLRU_ASSERT(hit_unique_a, $onehot0(hit_vec), "Key matched more than one slot.")
    `DLRU_ASSERT(oldest_found_a, nonempty == $onehot(old_vec), "Oldest entry not unique.")
    `DLRU_ASSERT(fill_count_a, $countones(valid_reg) == fill_reg, "Fill count off valid bits.")
    `DLRU_ASSERT_NEXT(pop_shrinks_a, do_pop, fill_reg == $past(fill_dec), "Pop kept fill.")

endmodule

FILE: bench/tb_dual_lru_block_cache_core.sv
module tb_dual_lru_block_cache_core;

    import dlru_pkg::*;

    // Request kind that the block must treat as a plain miss.
    localparam logic [FUNC_BITS-1:0] FUNC_UNKNOWN = 2'd3;

    // Register map and register indexes.
    localparam int CAP_ZERO_IDX = 0;
    localparam int CAP_ONE_IDX  = 1;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_CAP_ZERO = 3'd0;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_CAP_ONE  = 3'd4;

    // Run shape.
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 100;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    // Ready patterns of the result side.
    typedef enum int {
        SINK_READY,
        SINK_MOSTLY,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_mode_t;

    // Predicts both caches and holds the results still owed by the block.
    class lru_scoreboard_t;
        logic                 entry_valid [2][ENTRIES];
        logic [KEY_BITS-1:0]  entry_key   [2][ENTRIES];
        logic [DATA_BITS-1:0] entry_data  [2][ENTRIES];
        int unsigned          entry_rank  [2][ENTRIES];
        int unsigned          fill        [2];
        int unsigned          capacity    [2];
        dlru_res_t            owed_results [$];
        int                   mismatches;

        function new();
            foreach (entry_valid[c, i])
            begin
                entry_valid[c][i] = 1'b0;
                entry_key[c][i]   = '0;
                entry_data[c][i]  = '0;
                entry_rank[c][i]  = 0;
            end
            fill[0]     = 0;
            fill[1]     = 0;
            capacity[0] = 32'(CAP_RESET);
            capacity[1] = 32'(CAP_RESET);
            mismatches  = 0;
        endfunction

        function void set_capacity(int idx, logic [CAP_BITS-1:0] value);
            capacity[idx] = 32'(value);
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction

        // Out-of-range capacities are clamped to one and to the slot count.
        function int unsigned usable_capacity(int c);
            if (capacity[c] < 1)
                return 1;
            if (capacity[c] > ENTRIES)
                return ENTRIES;
            return capacity[c];
        endfunction

        function int find_key(int c, logic [KEY_BITS-1:0] key);
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (entry_valid[c][i] && entry_key[c][i] == key)
                    return i;
            end
            return -1;
        endfunction

        // Entries more recent than the touched one age by one step.
        function void promote(int c, int slot);
            int unsigned old_rank;
            old_rank = entry_rank[c][slot];
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (entry_valid[c][i] && entry_rank[c][i] < old_rank)
                    entry_rank[c][i]++;
            end
            entry_rank[c][slot] = 0;
        endfunction

        function int remove_oldest(int c);
            int oldest;
            oldest = -1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (entry_valid[c][i] &&
                    (oldest < 0 || entry_rank[c][i] > entry_rank[c][oldest]))
                    oldest = i;
            end
            if (oldest >= 0)
            begin
                entry_valid[c][oldest] = 1'b0;
                if (fill[c] > 0)
                    fill[c]--;
            end
            return oldest;
        endfunction

        // The new entry takes the lowest free slot; all others age.
        function void insert_entry(int c, logic [KEY_BITS-1:0] key,
                                   logic [DATA_BITS-1:0] data);
            int free_slot;
            free_slot = -1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (entry_valid[c][i])
                    entry_rank[c][i]++;
                else if (free_slot < 0)
                    free_slot = i;
            end
            if (free_slot >= 0)
            begin
                entry_valid[c][free_slot] = 1'b1;
                entry_key[c][free_slot]   = key;
                entry_data[c][free_slot]  = data;
                entry_rank[c][free_slot]  = 0;
                fill[c]++;
            end
        endfunction

        // Called for every request transfer; queues the result it must cause.
        function void note_request(logic [FUNC_BITS-1:0] func, int c,
                                   logic [KEY_BITS-1:0] key, logic [DATA_BITS-1:0] data);
            dlru_res_t res;
            int        slot;
            res = '0;
            res.status = ST_MISS;
            case (func)
                FUNC_GET:
                begin
                    slot = find_key(c, key);
                    if (slot >= 0)
                    begin
                        res.status = ST_HIT;
                        res.data   = entry_data[c][slot];
                        promote(c, slot);
                    end
                end
                FUNC_SET:
                begin
                    slot = find_key(c, key);
                    if (slot >= 0)
                    begin
                        entry_data[c][slot] = data;
                        promote(c, slot);
                        res.status = ST_UPDATED;
                    end
                    else
                    begin
                        res.status = ST_INSERTED;
                        if (fill[c] >= usable_capacity(c))
                        begin
                            slot = remove_oldest(c);
                            if (slot >= 0)
                            begin
                                res.status = ST_EVICTED;
                                res.key    = entry_key[c][slot];
                                res.data   = entry_data[c][slot];
                            end
                        end
                        insert_entry(c, key, data);
                    end
                end
                FUNC_POP:
                begin
                    slot = remove_oldest(c);
                    if (slot >= 0)
                    begin
                        res.status = ST_POPPED;
                        res.key    = entry_key[c][slot];
                        res.data   = entry_data[c][slot];
                    end
                    else
                        res.status = ST_EMPTY;
                end
                default:
                    res.status = ST_MISS;
            endcase
            owed_results.push_back(res);
        endfunction

        // Called for every result transfer.
        function void check_result(logic [OUT_TDATA-1:0] bus);
            logic [STATUS_BITS-1:0] got_status;
            logic [KEY_BITS-1:0]    got_key;
            logic [DATA_BITS-1:0]   got_data;
            dlru_res_t              want;
            got_status = bus[STATUS_BITS-1:0];
            got_key    = bus[STATUS_BITS +: KEY_BITS];
            got_data   = bus[STATUS_BITS + KEY_BITS +: DATA_BITS];
            if (owed_results.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected result: status %0d key %h data %h",
                             got_status, got_key, got_data);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got_status !== want.status || got_key !== want.key || got_data !== want.data)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display({"result mismatch: status exp %0d got %0d, ",
                              "key exp %h got %h, data exp %h got %h"},
                             want.status, got_status, want.key, got_key, want.data, got_data);
                mismatches++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_TDATA-1:0]      s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_TDATA-1:0]     m_tdata;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    lru_scoreboard_t sb;
    int              requests_accepted = 0;
    bit              backlog_done = 1'b0;

    dual_lru_block_cache_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    // Offers one request and waits for its transfer; tvalid stays high afterward.
    task automatic request(input logic [FUNC_BITS-1:0] func, input logic cache,
                           input logic [KEY_BITS-1:0] key, input logic [DATA_BITS-1:0] data);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA - IN_BITS){1'b0}}, data, key, func};
        s_tuser  <= cache;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(func, int'(cache), key, data);
        requests_accepted++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // Setup cycle, access cycle, then the port is deselected and left idle before returning.
    task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [CAP_BITS-1:0] value);
        logic [APB_DATA_BITS-1:0] word;
        word = $urandom();
        word[CAP_BITS-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Capacities change only once every owed result has been taken.
    task automatic set_capacities(input logic [CAP_BITS-1:0] cap_zero,
                                  input logic [CAP_BITS-1:0] cap_one);
        while (sb.outstanding() != 0)
            @(posedge clk);
        apb_write(ADDR_CAP_ZERO, cap_zero);
        sb.set_capacity(CAP_ZERO_IDX, cap_zero);
        apb_write(ADDR_CAP_ONE, cap_one);
        sb.set_capacity(CAP_ONE_IDX, cap_one);
    endtask

    // Result side: shifting ready patterns, plus one long hold-off to back up the block.
    initial
    begin : result_sink
        int unsigned tick;
        sink_mode_t  mode;
        m_tready <= 1'b0;
        tick = 0;
        mode = SINK_READY;
        forever
        begin
            @(posedge clk);
            if (rst_n && !backlog_done && requests_accepted >= HOLD_AFTER)
            begin
                backlog_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (tick % 48 == 0)
                    mode = sink_mode_t'($urandom_range(0, 3));
                tick++;
                case (mode)
                    SINK_READY:  m_tready <= 1'b1;
                    SINK_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    SINK_SPARSE: m_tready <= ($urandom_range(0, 9) < 3);
                    default:     m_tready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Result checking and the stall watchdog.
    always @(posedge clk)
    begin : monitor
        static int quiet_cycles = 0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no transfer for %0d cycles", QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int                   plan_zero [PHASES];
        int                   plan_one  [PHASES];
        logic [KEY_BITS-1:0]  key_pool [32];
        int                   pool_size;
        int                   sent;
        int                   burst;
        int                   gap;
        int                   roll;
        logic [FUNC_BITS-1:0] func;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] data;
        logic [CAP_BITS-1:0]  cap_zero;
        logic [CAP_BITS-1:0]  cap_one;

        plan_zero = '{16, 1, 0, 3, 31, 2};
        plan_one  = '{16, 2, 31, 16, 0, 1};
        sb = new();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty caches: a get misses, a pop finds nothing, an unknown kind is a miss.
        request(FUNC_GET, 1'b0, '0, '1);
        request(FUNC_POP, 1'b1, '1, '0);
        request(FUNC_UNKNOWN, 1'b0, '1, '1);
        // Key and payload extremes: insert, hit, update, hit again.
        request(FUNC_SET, 1'b0, '0, '0);
        request(FUNC_SET, 1'b0, '1, '1);
        request(FUNC_GET, 1'b0, '0, '0);
        request(FUNC_SET, 1'b0, '1, 64'h0123_4567_89ab_cdef);
        request(FUNC_GET, 1'b0, '1, '0);
        // The caches are independent: a key held by one misses in the other; then pop the least recent.
        request(FUNC_SET, 1'b1, 31'h2aaa_aaaa, 64'h5555_5555_aaaa_aaaa);
        request(FUNC_GET, 1'b1, 31'h2aaa_aaaa, '0);
        request(FUNC_GET, 1'b0, 31'h2aaa_aaaa, '0);
        request(FUNC_POP, 1'b0, '0, '0);
        stop_sending();

        // A capacity of zero acts as one; a capacity above the slot count acts as full size.
        set_capacities(5'd0, 5'd31);
        request(FUNC_SET, 1'b0, 31'h1, 64'h1111);
        request(FUNC_SET, 1'b0, 31'h2, 64'h2222);
        request(FUNC_SET, 1'b1, 31'h3, 64'h3333);
        stop_sending();
        set_capacities(5'd16, 5'd31);
        request(FUNC_SET, 1'b0, 31'h4, 64'h4444);
        request(FUNC_SET, 1'b0, 31'h5, 64'h5555);
        request(FUNC_SET, 1'b0, 31'h6, 64'h6666);
        stop_sending();

        // Capacity lowered below the fill: each new key evicts one and keeps the fill.
        set_capacities(5'd2, 5'd1);
        request(FUNC_SET, 1'b0, 31'h7, 64'h7777);
        request(FUNC_SET, 1'b1, 31'h8, 64'h8888);
        request(FUNC_POP, 1'b0, '0, '0);
        request(FUNC_POP, 1'b0, '0, '0);
        stop_sending();

        // Random phases, each with its own capacities and its own key pool.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            cap_zero = CAP_BITS'(plan_zero[phase]);
            cap_one  = CAP_BITS'(plan_one[phase]);
            if (phase == 4)
            begin
                cap_zero = CAP_BITS'($urandom_range(0, 31));
                cap_one  = CAP_BITS'($urandom_range(0, 31));
            end
            set_capacities(cap_zero, cap_one);
            pool_size = $urandom_range(4, 28);
            for (int i = 0; i < 32; i++)
                key_pool[i] = KEY_BITS'($urandom());

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) == 0)
                    burst = $urandom_range(30, 80);
                else
                    burst = $urandom_range(1, 12);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 35)
                        func = FUNC_GET;
                    else if (roll < 75)
                        func = FUNC_SET;
                    else if (roll < 95)
                        func = FUNC_POP;
                    else
                        func = FUNC_UNKNOWN;
                    if ($urandom_range(0, 9) == 0)
                        key = KEY_BITS'($urandom());
                    else
                        key = key_pool[$urandom_range(0, pool_size - 1)];
                    data = {$urandom(), $urandom()};
                    request(func, 1'($urandom_range(0, 1)), key, data);
                    sent++;
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    stop_sending();
                    repeat (gap) @(posedge clk);
                end
            end
            stop_sending();
        end

        // Drain, then give any stray result time to show up.
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.outstanding() == 0 && sb.mismatches == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.outstanding());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
